@@ hw/rtl/composite_name_splitter_assert.svh @@
// ----------------------------------------------------------------------------
// composite_name_splitter_assert.svh
// Assertion macros for the composite name splitter RTL
// ----------------------------------------------------------------------------
`ifndef COMPOSITE_NAME_SPLITTER_ASSERT_SVH
`define COMPOSITE_NAME_SPLITTER_ASSERT_SVH

// condition holds at every clock edge out of reset
`define CNS_ASSERT_ALWAYS(lbl, expr, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) \
        else $error(msg);

// antecedent implies consequent in the same cycle
`define CNS_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// antecedent implies consequent in the next cycle
`define CNS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

@@ hw/rtl/cns_pkg.sv @@
// ----------------------------------------------------------------------------
// cns_pkg
// Types and character constants for the composite name splitter
// ----------------------------------------------------------------------------
package cns_pkg;

    // meta characters
    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_SQUOTE = 8'h27;

    // result queue depth and its count width
    localparam int QDEPTH = 6;
    localparam int QIDX_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    // parser mode
    typedef enum logic [2:0] {
        MODE_START  = 3'd0,
        MODE_COMP   = 3'd1,
        MODE_ESC    = 3'd2,
        MODE_QUOTED = 3'd3,
        MODE_QESC   = 3'd4,
        MODE_AFTERQ = 3'd5
    } t_mode;

    // full parser state
    typedef struct packed {
        t_mode mode;
        logic  quote_kind;   // 0 double quote, 1 single quote
        logic  name_bad;
    } t_parse_state;

    // one result word
    typedef struct packed {
        logic       byte_valid;
        logic [7:0] out_byte;
        logic       comp_end;
        logic       name_end;
        logic       illegal;
        logic       run_last;
    } t_result;

    localparam t_parse_state PARSE_RESET = '{mode: MODE_START, quote_kind: 1'b0,
                                             name_bad: 1'b0};

    // component character word
    function automatic t_result char_res(input logic [7:0] b);
        t_result r;
        r            = '0;
        r.byte_valid = 1'b1;
        r.out_byte   = b;
        return r;
    endfunction

    // component end word, optionally also name end
    function automatic t_result end_res(input logic name_end);
        t_result r;
        r          = '0;
        r.comp_end = 1'b1;
        r.name_end = name_end;
        return r;
    endfunction

    // malformed name end word
    function automatic t_result bad_res();
        t_result r;
        r          = '0;
        r.name_end = 1'b1;
        r.illegal  = 1'b1;
        return r;
    endfunction

    function automatic logic is_meta(input logic [7:0] b);
        return (b == CH_SLASH) || (b == CH_BSLASH) || (b == CH_DQUOTE) ||
               (b == CH_SQUOTE);
    endfunction

endpackage

@@ hw/rtl/cns_decode.sv @@
// ----------------------------------------------------------------------------
// cns_decode
// Parser step: next state and up to two result words for one name byte
// ----------------------------------------------------------------------------
module cns_decode import cns_pkg::*; (
    input  logic [7:0]   i_byte,
    input  t_parse_state i_state,
    output t_parse_state o_state,
    output logic [1:0]   o_count,
    output t_result      o_res0,
    output t_result      o_res1
);

    logic [7:0] qchar;
    logic       is_q;
    t_result    res0;
    t_result    res1;
    logic [1:0] count;

    assign qchar = i_state.quote_kind ? CH_SQUOTE : CH_DQUOTE;
    assign is_q  = (i_byte == qchar);

    // next state
    always_comb begin
        o_state = i_state;
        if (i_byte == CH_NUL) begin
            o_state = PARSE_RESET;
        end else if (!i_state.name_bad) begin
            unique case (i_state.mode)
                MODE_ESC: begin
                    o_state.mode = MODE_COMP;
                end
                MODE_QUOTED: begin
                    if (is_q) begin
                        o_state.mode = MODE_AFTERQ;
                    end else if (i_byte == CH_BSLASH) begin
                        o_state.mode = MODE_QESC;
                    end
                end
                MODE_QESC: begin
                    if (is_q) begin
                        o_state.mode = MODE_QUOTED;
                    end else if (i_byte == CH_BSLASH) begin
                        o_state.mode = MODE_QESC;
                    end else begin
                        o_state.mode = MODE_QUOTED;
                    end
                end
                MODE_AFTERQ: begin
                    if (i_byte == CH_SLASH) begin
                        o_state.mode = MODE_START;
                    end else begin
                        o_state.name_bad = 1'b1;
                    end
                end
                default: begin
                    // start of component, inside a component, unused codes
                    priority if (i_byte == CH_SLASH) begin
                        o_state.mode = MODE_START;
                    end else if (i_byte == CH_BSLASH) begin
                        o_state.mode = MODE_ESC;
                    end else if (i_state.mode == MODE_START &&
                                 (i_byte == CH_DQUOTE || i_byte == CH_SQUOTE)) begin
                        o_state.quote_kind = (i_byte == CH_SQUOTE);
                        o_state.mode       = MODE_QUOTED;
                    end else begin
                        o_state.mode = MODE_COMP;
                    end
                end
            endcase
        end
    end

    // result words
    always_comb begin
        res0  = '0;
        res1  = '0;
        count = 2'd0;
        if (i_byte == CH_NUL) begin
            if (i_state.name_bad || i_state.mode == MODE_QUOTED ||
                i_state.mode == MODE_QESC) begin
                res0  = bad_res();
                count = 2'd1;
            end else if (i_state.mode == MODE_ESC) begin
                // trailing backslash stays literal
                res0  = char_res(CH_BSLASH);
                res1  = end_res(1'b1);
                count = 2'd2;
            end else begin
                res0  = end_res(1'b1);
                count = 2'd1;
            end
        end else if (!i_state.name_bad) begin
            unique case (i_state.mode)
                MODE_ESC: begin
                    if (is_meta(i_byte)) begin
                        res0  = char_res(i_byte);
                        count = 2'd1;
                    end else begin
                        res0  = char_res(CH_BSLASH);
                        res1  = char_res(i_byte);
                        count = 2'd2;
                    end
                end
                MODE_QUOTED: begin
                    if (!is_q && i_byte != CH_BSLASH) begin
                        res0  = char_res(i_byte);
                        count = 2'd1;
                    end
                end
                MODE_QESC: begin
                    if (is_q) begin
                        res0  = char_res(i_byte);
                        count = 2'd1;
                    end else if (i_byte == CH_BSLASH) begin
                        res0  = char_res(CH_BSLASH);
                        count = 2'd1;
                    end else begin
                        res0  = char_res(CH_BSLASH);
                        res1  = char_res(i_byte);
                        count = 2'd2;
                    end
                end
                MODE_AFTERQ: begin
                    if (i_byte == CH_SLASH) begin
                        res0  = end_res(1'b0);
                        count = 2'd1;
                    end
                end
                default: begin
                    priority if (i_byte == CH_SLASH) begin
                        res0  = end_res(1'b0);
                        count = 2'd1;
                    end else if (i_byte == CH_BSLASH) begin
                        count = 2'd0;
                    end else if (i_state.mode == MODE_START &&
                                 (i_byte == CH_DQUOTE || i_byte == CH_SQUOTE)) begin
                        count = 2'd0;
                    end else begin
                        res0  = char_res(i_byte);
                        count = 2'd1;
                    end
                end
            endcase
        end
        // mark the last word of this byte
        if (count == 2'd1) begin
            res0.run_last = 1'b1;
        end
        if (count == 2'd2) begin
            res1.run_last = 1'b1;
        end
    end

    assign o_res0  = res0;
    assign o_res1  = res1;
    assign o_count = count;

endmodule

@@ hw/rtl/composite_name_splitter.sv @@
// ----------------------------------------------------------------------------
// composite_name_splitter
// Splits a slash separated composite name into unescaped components
// ----------------------------------------------------------------------------
// Input channel: one name byte per word on i_in_byte, accepted when
// i_in_valid is high and o_in_stall is low; a zero byte ends the name.
// Output channel: result words on the o_ field ports, taken when o_out_valid
// is high and i_out_stall is low. Each input byte gives zero, one or two
// words; the last word of a byte carries o_run_last.
// An accepted byte is held in the input byte register and parsed from there
// into the result queue; its words are offered in order from the queue head.
// Throughput: one byte per cycle while each byte gives at most one word and
// the receiver does not stall; the output side drains one word per cycle,
// so bytes giving two words (kept escapes, trailing backslash) back up input.
// Input stall comes from the six entry result queue fill level and the
// byte in the parse register, never from i_out_stall directly.
// A stalled receiver just lets the queue fill; the head word holds.
// Reset: synchronous, active low; clears parser state and empties the
// queue, the next byte starts a new name.
// ----------------------------------------------------------------------------
module composite_name_splitter import cns_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // input byte channel
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [7:0] i_in_byte,
    // result channel
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic       o_byte_valid,
    output logic [7:0] o_out_byte,
    output logic       o_comp_end,
    output logic       o_name_end,
    output logic       o_illegal,
    output logic       o_run_last
);

    logic               r_in_valid;
    logic [7:0]         r_in_byte;
    t_parse_state       r_state;
    t_parse_state       n_state;
    t_result            r_q [QDEPTH];
    t_result            n_q [QDEPTH];
    logic [QCNT_W-1:0]  r_cnt;
    logic [QCNT_W-1:0]  n_cnt;

    t_parse_state       dec_state;
    logic [1:0]         dec_count;
    t_result            dec_res0;
    t_result            dec_res1;
    logic [1:0]         push_cnt;
    logic               in_accept;
    logic               pop;
    logic [QIDX_W-1:0]  base;
    logic [QCNT_W:0]    fill_ahead;

    // parse step on the registered byte
    cns_decode u_decode (
        .i_byte  (r_in_byte),
        .i_state (r_state),
        .o_state (dec_state),
        .o_count (dec_count),
        .o_res0  (dec_res0),
        .o_res1  (dec_res1)
    );

    assign push_cnt = r_in_valid ? dec_count : 2'd0;
    assign pop      = (r_cnt != '0) && !i_out_stall;

    // room for the parsed byte plus two more words after it
    assign fill_ahead = {1'b0, r_cnt} + {{(QCNT_W - 1){1'b0}}, push_cnt};
    assign o_in_stall = fill_ahead > (QCNT_W + 1)'(QDEPTH - 2);
    assign in_accept  = i_in_valid && !o_in_stall;

    // input byte register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= in_accept;
        end
        if (in_accept) begin
            r_in_byte <= i_in_byte;
        end
    end

    // parser state advances when the registered byte is parsed
    assign n_state = r_in_valid ? dec_state : r_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= PARSE_RESET;
        end else begin
            r_state <= n_state;
        end
    end

    // result queue: head at entry 0, shift on pop, append new words
    assign base = QIDX_W'(r_cnt - {{(QCNT_W - 1){1'b0}}, pop});

    always_comb begin
        for (int i = 0; i < QDEPTH - 1; i++) begin
            n_q[i] = pop ? r_q[i + 1] : r_q[i];
        end
        n_q[QDEPTH - 1] = r_q[QDEPTH - 1];
        for (int i = 0; i < QDEPTH; i++) begin
            if (push_cnt != 2'd0 && QIDX_W'(i) == base) begin
                n_q[i] = dec_res0;
            end
            if (push_cnt == 2'd2 && QIDX_W'(i) == base + QIDX_W'(1)) begin
                n_q[i] = dec_res1;
            end
        end
        n_cnt = r_cnt - {{(QCNT_W - 1){1'b0}}, pop}
                      + {{(QCNT_W - 2){1'b0}}, push_cnt};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
        r_q <= n_q;
    end

    // output word from the queue head
    assign o_out_valid  = (r_cnt != '0);
    assign o_byte_valid = r_q[0].byte_valid;
    assign o_out_byte   = r_q[0].out_byte;
    assign o_comp_end   = r_q[0].comp_end;
    assign o_name_end   = r_q[0].name_end;
    assign o_illegal    = r_q[0].illegal;
    assign o_run_last   = r_q[0].run_last;

    // checks
`include "composite_name_splitter_assert.svh"

    `CNS_ASSERT_ALWAYS(a_queue_bound, r_cnt <= QCNT_W'(QDEPTH), "result queue overflow")
    `CNS_ASSERT_NEXT(a_accept_parsed, in_accept, r_in_valid, "accepted byte not parsed")
    `CNS_ASSERT_IMPL(a_name_end_last, o_out_valid && o_name_end, o_run_last, "name end not last word")
    `CNS_ASSERT_IMPL(a_illegal_end, o_out_valid && o_illegal, o_name_end && !o_byte_valid, "illegal word malformed")
    `CNS_ASSERT_NEXT(a_end_clears, r_in_valid && r_in_byte == CH_NUL, r_state == PARSE_RESET, "state not cleared at name end")

endmodule

@@ test/cns_split_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cns_split_checker
// Watches both channels of the composite name splitter, predicts the result
// words of every accepted name byte and compares each taken result word,
// field by field, with the oldest predicted word
// ----------------------------------------------------------------------------
module cns_split_checker import cns_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // name byte channel
    input  logic       i_in_valid,
    input  logic       i_in_stall,
    input  logic [7:0] i_in_byte,
    // result channel
    input  logic       i_out_valid,
    input  logic       i_out_stall,
    input  logic       i_byte_valid,
    input  logic [7:0] i_out_byte,
    input  logic       i_comp_end,
    input  logic       i_name_end,
    input  logic       i_illegal,
    input  logic       i_run_last,
    // status for the top
    output int         o_fail_count,
    output int         o_pending,
    output int         o_word_count,
    output int         o_name_count,
    output int         o_bad_name_count
);

    // predicted parser state
    t_mode      split_mode;
    logic       quote_single;
    logic       name_broken;

    t_result    expected_words[$];
    int         fail_count     = 0;
    int         word_count     = 0;
    int         name_count     = 0;
    int         bad_name_count = 0;

    function automatic t_result make_word(input logic valid, input logic [7:0] b,
                                          input logic ce, input logic ne,
                                          input logic ill);
        t_result w;
        w            = '0;
        w.byte_valid = valid;
        w.out_byte   = b;
        w.comp_end   = ce;
        w.name_end   = ne;
        w.illegal    = ill;
        return w;
    endfunction

    task automatic clear_split_state();
        split_mode   = MODE_START;
        quote_single = 1'b0;
        name_broken  = 1'b0;
    endtask

    // one line per mismatch
    task automatic report_mismatch(input string what);
        fail_count++;
        $display("ERROR at %0t ns: %s", $time, what);
    endtask

    // expected result words of one accepted name byte
    task automatic split_byte(input logic [7:0] b);
        t_result    words[$];
        logic [7:0] qc;
        logic       meta;
        qc   = quote_single ? CH_SQUOTE : CH_DQUOTE;
        meta = (b == CH_SLASH) || (b == CH_BSLASH) || (b == CH_DQUOTE) ||
               (b == CH_SQUOTE);
        if (b == CH_NUL) begin
            if (name_broken || split_mode == MODE_QUOTED || split_mode == MODE_QESC) begin
                words.push_back(make_word(1'b0, 8'h00, 1'b0, 1'b1, 1'b1));
            end else begin
                // trailing backslash stays a literal
                if (split_mode == MODE_ESC)
                    words.push_back(make_word(1'b1, CH_BSLASH, 1'b0, 1'b0, 1'b0));
                words.push_back(make_word(1'b0, 8'h00, 1'b1, 1'b1, 1'b0));
            end
            clear_split_state();
        end else if (!name_broken) begin
            case (split_mode)
                MODE_ESC: begin
                    // backslash only dropped before a meta character
                    if (!meta)
                        words.push_back(make_word(1'b1, CH_BSLASH, 1'b0, 1'b0, 1'b0));
                    words.push_back(make_word(1'b1, b, 1'b0, 1'b0, 1'b0));
                    split_mode = MODE_COMP;
                end
                MODE_QUOTED, MODE_QESC: begin
                    if (split_mode == MODE_QESC && b == qc) begin
                        words.push_back(make_word(1'b1, b, 1'b0, 1'b0, 1'b0));
                        split_mode = MODE_QUOTED;
                    end else begin
                        // kept backslash, then the byte is parsed as usual
                        if (split_mode == MODE_QESC)
                            words.push_back(make_word(1'b1, CH_BSLASH, 1'b0, 1'b0, 1'b0));
                        split_mode = MODE_QUOTED;
                        if (b == qc)
                            split_mode = MODE_AFTERQ;
                        else if (b == CH_BSLASH)
                            split_mode = MODE_QESC;
                        else
                            words.push_back(make_word(1'b1, b, 1'b0, 1'b0, 1'b0));
                    end
                end
                MODE_AFTERQ: begin
                    if (b == CH_SLASH) begin
                        words.push_back(make_word(1'b0, 8'h00, 1'b1, 1'b0, 1'b0));
                        split_mode = MODE_START;
                    end else begin
                        name_broken = 1'b1;
                    end
                end
                default: begin
                    if (b == CH_SLASH) begin
                        words.push_back(make_word(1'b0, 8'h00, 1'b1, 1'b0, 1'b0));
                        split_mode = MODE_START;
                    end else if (b == CH_BSLASH) begin
                        split_mode = MODE_ESC;
                    end else if (split_mode == MODE_START &&
                                 (b == CH_DQUOTE || b == CH_SQUOTE)) begin
                        quote_single = (b == CH_SQUOTE);
                        split_mode   = MODE_QUOTED;
                    end else begin
                        words.push_back(make_word(1'b1, b, 1'b0, 1'b0, 1'b0));
                        split_mode = MODE_COMP;
                    end
                end
            endcase
        end
        if (words.size() > 0)
            words[words.size() - 1].run_last = 1'b1;
        foreach (words[k])
            expected_words.push_back(words[k]);
    endtask

    task automatic check_word();
        t_result want;
        if (expected_words.size() == 0) begin
            report_mismatch($sformatf("result word with nothing expected (byte %02h)",
                                      i_out_byte));
            return;
        end
        want = expected_words.pop_front();
        word_count++;
        if (i_byte_valid !== want.byte_valid)
            report_mismatch($sformatf("byte_valid exp %0b got %0b", want.byte_valid,
                                      i_byte_valid));
        if (i_out_byte !== want.out_byte)
            report_mismatch($sformatf("out_byte exp %02h got %02h", want.out_byte,
                                      i_out_byte));
        if (i_comp_end !== want.comp_end)
            report_mismatch($sformatf("comp_end exp %0b got %0b", want.comp_end,
                                      i_comp_end));
        if (i_name_end !== want.name_end)
            report_mismatch($sformatf("name_end exp %0b got %0b", want.name_end,
                                      i_name_end));
        if (i_illegal !== want.illegal)
            report_mismatch($sformatf("illegal exp %0b got %0b", want.illegal,
                                      i_illegal));
        if (i_run_last !== want.run_last)
            report_mismatch($sformatf("run_last exp %0b got %0b", want.run_last,
                                      i_run_last));
        if (want.name_end) begin
            name_count++;
            if (want.illegal)
                bad_name_count++;
        end
    endtask

    // taken word is checked before the byte of the same edge is predicted
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_split_state();
            expected_words.delete();
        end else begin
            if (i_out_valid && !i_out_stall)
                check_word();
            if (i_in_valid && !i_in_stall)
                split_byte(i_in_byte);
        end
        o_fail_count     <= fail_count;
        o_pending        <= expected_words.size();
        o_word_count     <= word_count;
        o_name_count     <= name_count;
        o_bad_name_count <= bad_name_count;
    end

endmodule

@@ test/tb_composite_name_splitter.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_composite_name_splitter
// Drives the composite name splitter with directed names covering escapes,
// quoting and malformed endings, then with random names, under three idle
// profiles and long output holds; the checker does the comparing
// ----------------------------------------------------------------------------
module tb_composite_name_splitter import cns_pkg::*; ();

    localparam int CLK_HALF      = 4;
    localparam int TIMEOUT_CYC   = 500_000;
    localparam int HOLD_CYCLES   = 60;
    localparam int ITEMS_PHASE_0 = 570;
    localparam int ITEMS_PHASE_1 = 1140;
    localparam int ITEMS_TOTAL   = 1700;

    logic       i_clk        = 1'b0;
    logic       i_rst_n      = 1'b0;
    logic       i_in_valid   = 1'b0;
    logic [7:0] i_in_byte    = 8'h00;
    logic       i_out_stall  = 1'b0;
    logic       o_in_stall;
    logic       o_out_valid;
    logic       o_byte_valid;
    logic [7:0] o_out_byte;
    logic       o_comp_end;
    logic       o_name_end;
    logic       o_illegal;
    logic       o_run_last;

    int         fail_count;
    int         pending_words;
    int         word_count;
    int         name_count;
    int         bad_name_count;

    int         send_idle_pct = 0;
    int         recv_idle_pct = 0;
    bit         hold_request  = 1'b0;
    int         hold_left     = 0;
    int         sent_items    = 0;
    bit         swallowing    = 1'b0;

    composite_name_splitter uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_in_byte    (i_in_byte),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_byte_valid (o_byte_valid),
        .o_out_byte   (o_out_byte),
        .o_comp_end   (o_comp_end),
        .o_name_end   (o_name_end),
        .o_illegal    (o_illegal),
        .o_run_last   (o_run_last)
    );

    cns_split_checker u_checker (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .i_in_stall       (o_in_stall),
        .i_in_byte        (i_in_byte),
        .i_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .i_byte_valid     (o_byte_valid),
        .i_out_byte       (o_out_byte),
        .i_comp_end       (o_comp_end),
        .i_name_end       (o_name_end),
        .i_illegal        (o_illegal),
        .i_run_last       (o_run_last),
        .o_fail_count     (fail_count),
        .o_pending        (pending_words),
        .o_word_count     (word_count),
        .o_name_count     (name_count),
        .o_bad_name_count (bad_name_count)
    );

    always #(CLK_HALF) i_clk = ~i_clk;

    // hard stop
    initial begin
        #(TIMEOUT_CYC * 2 * CLK_HALF);
        $display("timeout waiting for result words");
        $display("composite_name_splitter regression: fail");
        $finish;
    end

    // receiver: random stalls, or one long hold on request
    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            hold_left   <= hold_left - 1;
            i_out_stall <= 1'b1;
        end else if (hold_request) begin
            hold_request = 1'b0;
            hold_left   <= HOLD_CYCLES - 1;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
        end
    end

    // offer one name byte, with random gaps, until it is taken
    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_byte  <= b;
        do @(posedge i_clk); while (o_in_stall);
        // bytes of a name already known bad are just dropped by the block
        if (!swallowing)
            sent_items++;
        if (b == CH_NUL)
            swallowing = 1'b0;
    endtask

    // nonzero name byte with meta characters well represented
    function automatic logic [7:0] pick_name_byte();
        case ($urandom_range(0, 15))
            0:       return CH_SLASH;
            1:       return CH_BSLASH;
            2:       return CH_DQUOTE;
            3:       return CH_SQUOTE;
            default: return 8'($urandom_range(1, 255));
        endcase
    endfunction

    // mostly well formed names, some unterminated quotes, junk after
    // closing quotes and plain noise
    task automatic send_random_name();
        int         n_comp;
        int         len;
        int         flavor;
        logic [7:0] q;
        logic [7:0] b;
        if ($urandom_range(0, 9) == 0) begin
            repeat ($urandom_range(1, 8)) send_byte(8'($urandom_range(1, 255)));
            send_byte(CH_NUL);
            return;
        end
        n_comp = $urandom_range(1, 4);
        for (int c = 0; c < n_comp; c++) begin
            if (c > 0)
                send_byte(CH_SLASH);
            len = $urandom_range(0, 5);
            if ($urandom_range(0, 9) < 3) begin
                q = ($urandom_range(0, 1) != 0) ? CH_SQUOTE : CH_DQUOTE;
                send_byte(q);
                repeat (len) begin
                    b = pick_name_byte();
                    // quote inside the span goes escaped, backslash gets a follower
                    if (b == q || b == CH_BSLASH) begin
                        send_byte(CH_BSLASH);
                        if (b == CH_BSLASH) begin
                            b = pick_name_byte();
                            if (b == CH_BSLASH)
                                b = q;
                        end
                    end
                    send_byte(b);
                end
                flavor = $urandom_range(0, 19);
                if (flavor != 0)
                    send_byte(q);
                if (flavor == 1) begin
                    b = 8'($urandom_range(1, 255));
                    send_byte((b == CH_SLASH) ? 8'hFF : b);
                    swallowing = 1'b1;
                end
            end else begin
                repeat (len) send_byte(pick_name_byte());
            end
        end
        send_byte(CH_NUL);
    endtask

    // stimulus and verdict
    initial begin
        logic [7:0] directed_bytes[$];
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // sender idles lightly, receiver heavily
        send_idle_pct = 21;
        recv_idle_pct = 80;

        // empty component, kept escapes of extreme bytes, escaped slash,
        // trailing backslash
        directed_bytes = {CH_SLASH, CH_BSLASH, 8'h01, 8'hFF, CH_BSLASH, 8'hFE,
                          CH_SLASH, CH_BSLASH, CH_SLASH, CH_BSLASH, CH_NUL};
        // single quotes: kept backslash then new escape, escaped quote,
        // close, then an unterminated double quote
        directed_bytes = {directed_bytes, CH_SQUOTE, 8'h61, CH_BSLASH, CH_BSLASH,
                          CH_BSLASH, CH_SQUOTE, CH_SQUOTE, CH_SLASH, CH_DQUOTE,
                          CH_NUL};
        // junk after a closing quote, then an escape left open in quotes
        directed_bytes = {directed_bytes, CH_DQUOTE, 8'h78, CH_DQUOTE, 8'h79,
                          8'hFF, CH_NUL, CH_DQUOTE, CH_BSLASH, CH_NUL};
        foreach (directed_bytes[k]) begin
            send_byte(directed_bytes[k]);
            if (k == 23)
                swallowing = 1'b1;
        end

        while (sent_items < ITEMS_PHASE_0) begin
            if (sent_items > ITEMS_PHASE_0 / 2 && hold_left == 0 && !hold_request &&
                sent_items < ITEMS_PHASE_0 / 2 + 20)
                hold_request = 1'b1;
            send_random_name();
        end

        // sender idles heavily, receiver lightly
        send_idle_pct = 80;
        recv_idle_pct = 21;
        while (sent_items < ITEMS_PHASE_1)
            send_random_name();

        // no idling, and the receiver holds off long enough to back up the input
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_request  = 1'b1;
        while (sent_items < ITEMS_TOTAL)
            send_random_name();

        i_in_valid <= 1'b0;
        repeat (2) @(posedge i_clk);
        while (pending_words != 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        $display("sent %0d name bytes under three idle profiles and long output holds",
                 sent_items);
        $display("checked %0d result words over %0d names, %0d of them malformed",
                 word_count, name_count, bad_name_count);
        if (fail_count == 0 && pending_words == 0) begin
            $display("composite_name_splitter regression: pass");
        end else begin
            $display("%0d mismatches, %0d words still expected", fail_count,
                     pending_words);
            $display("composite_name_splitter regression: fail");
        end
        $finish;
    end

endmodule

@@ sim.f @@
+incdir+hw/rtl
hw/rtl/cns_pkg.sv
hw/rtl/cns_decode.sv
hw/rtl/composite_name_splitter.sv
test/cns_split_checker.sv
test/tb_composite_name_splitter.sv
